FILE: rtl/phx_pkg.sv
// Package for the polyline hit test block: item types, field widths and default parameters.
// Used by polyline_hit_test_xz, phx_seg and the testbench; depends on nothing.
package phx_pkg;

    localparam int MAX_VERTICES_DEF  = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W  = 32;
    localparam int TOL_W    = 31;
    localparam int TOLSQ_W  = 2 * TOL_W;
    localparam int VCOUNT_W = 9;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = DIFF_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int DIST_W   = PROD_W + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                        command;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_z;
    } t_item;

    typedef struct packed {
        logic                        hit;
        logic [VCOUNT_W-1:0]         vertex_count;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0]   ax;
        logic signed [COORD_W-1:0]   az;
        logic signed [COORD_W-1:0]   bx;
        logic signed [COORD_W-1:0]   bz;
        logic signed [COORD_W-1:0]   px;
        logic signed [COORD_W-1:0]   pz;
    } t_seg;

endpackage

FILE: rtl/polyline_hit_test_xz.sv
// Polyline hit test in the XZ plane: vertex store in RAM, query walk and result register.
// Depends on phx_pkg, phx_ram and phx_seg.
// Clear and append give no result; a query on fewer than two vertices strobes its result
// in the cycle after it is taken, and a longer query walks its segments in turn through the
// segment unit's shared multiplier and one-bit-per-cycle divider; it stops early at the
// first hit. One item at a time, and results cannot be stalled. Synchronous reset empties
// the store and sets the tolerance to 1.0; the vertex RAM is not cleared.
module polyline_hit_test_xz
    import phx_pkg::*;
#(
    parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_result          o_result
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int RAM_W = 2 * COORD_W;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

    typedef enum logic [1:0] {
        S_IDLE, S_FIRST, S_NEXT, S_WAIT
    } t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic [TOL_W-1:0]          r_tol;
    logic [TOLSQ_W-1:0]        r_tol_sq;
    logic signed [COORD_W-1:0] r_px, r_pz, r_ax, r_az, r_bx, r_bz;
    logic                      r_done;
    t_result                   r_res;

    logic                      accept;
    logic                      ram_we;
    logic [AW-1:0]             ram_raddr;
    logic [RAM_W-1:0]          ram_rdata;
    logic [CW-1:0]             n_idx;
    logic                      seg_go;
    t_seg                      seg_req;
    logic                      seg_done;
    logic [DIST_W-1:0]         seg_dist;

    assign o_busy = r_state != S_IDLE;
    assign accept = i_start && !o_busy;
    assign ram_we = accept && i_item.command == CMD_APPEND
                    && r_count < CW'(MAX_VERTICES);
    assign n_idx  = r_idx + CW'(1);
    assign seg_go = r_state == S_NEXT;

    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_raddr = '0;
            S_WAIT:  ram_raddr = n_idx[AW-1:0];
            default: ram_raddr = r_idx[AW-1:0];
        endcase
    end

    always_comb begin
        seg_req.ax = r_ax;
        seg_req.az = r_az;
        seg_req.bx = ram_rdata[RAM_W-1:COORD_W];
        seg_req.bz = ram_rdata[COORD_W-1:0];
        seg_req.px = r_px;
        seg_req.pz = r_pz;
    end

    phx_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_item.coord_x, i_item.coord_z}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    phx_seg #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (seg_go),
        .i_seg     (seg_req),
        .o_done    (seg_done),
        .o_dist_sq (seg_dist)
    );

    always_ff @(posedge i_clk) begin
        r_tol_sq <= r_tol * r_tol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tol   <= TOL_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_item.command)
                            CMD_CLEAR: r_count <= '0;
                            CMD_APPEND: begin
                                if (r_count < CW'(MAX_VERTICES)) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            CMD_QUERY: begin
                                r_px <= i_item.coord_x;
                                r_pz <= i_item.coord_z;
                                if (r_count < CW'(2)) begin
                                    r_done             <= 1'b1;
                                    r_res.hit          <= 1'b0;
                                    r_res.vertex_count <= VCOUNT_W'(r_count);
                                end else begin
                                    r_idx   <= CW'(1);
                                    r_state <= S_FIRST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIRST: begin
                    r_ax    <= ram_rdata[RAM_W-1:COORD_W];
                    r_az    <= ram_rdata[COORD_W-1:0];
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_bx    <= ram_rdata[RAM_W-1:COORD_W];
                    r_bz    <= ram_rdata[COORD_W-1:0];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (seg_done) begin
                        priority if (seg_dist <= DIST_W'(r_tol_sq)) begin
                            r_done             <= 1'b1;
                            r_res.hit          <= 1'b1;
                            r_res.vertex_count <= VCOUNT_W'(r_count);
                            r_state            <= S_IDLE;
                        end else if (n_idx >= r_count) begin
                            r_done             <= 1'b1;
                            r_res.hit          <= 1'b0;
                            r_res.vertex_count <= VCOUNT_W'(r_count);
                            r_state            <= S_IDLE;
                        end else begin
                            r_ax    <= r_bx;
                            r_az    <= r_bz;
                            r_idx   <= n_idx;
                            r_state <= S_NEXT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !ram_we)
        else $error("vertex store written during a query walk");

    a_seg_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_done |-> r_state == S_WAIT)
        else $error("segment result arrived outside the wait state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NEXT |-> r_idx < r_count && r_idx != '0)
        else $error("segment end index outside the stored vertices");

    a_hit_needs_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.hit |-> r_count >= CW'(2))
        else $error("hit reported with fewer than two vertices");

endmodule

FILE: rtl/phx_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module phx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/phx_seg.sv
// Squared distance from a point to one segment, using one shared multiplier and a
// bit-serial divider for the projection parameter. Depends on phx_pkg.
module phx_seg
    import phx_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  t_seg              i_seg,
    output logic              o_done,
    output logic [DIST_W-1:0] o_dist_sq
);

    localparam int TQ_W  = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(FRACTION_BITS);
    localparam int OFS_W = DIFF_W + 1;
    localparam int EXT_W = DIFF_W + 2;
    localparam logic [DIST_W-1:0] LEN_THRESHOLD =
        (DIST_W'(1) << (2 * FRACTION_BITS)) / DIST_W'(100000);
    localparam logic [TQ_W-1:0]  TQ_ONE   = TQ_W'(1) << FRACTION_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LX, S_LZ, S_WX, S_WZ, S_DOT, S_TQ, S_DIV,
        S_OX, S_OZ, S_EX, S_EZ, S_SUM
    } t_state;

    t_state                    r_state;
    logic signed [DIFF_W-1:0]  r_dx, r_dz, r_wx, r_wz, r_ex, r_ez;
    logic [DIST_W-1:0]         r_len, r_rem, r_dist;
    logic [PROD_W-1:0]         r_prod, r_p1, r_dot, r_acc;
    logic                      r_neg;
    logic [TQ_W-1:0]           r_tq;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;

    logic [MAG_W-1:0]          mul_a, mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic                      n1, n2;
    logic [PROD_W-1:0]         n_dot;
    logic                      n_neg;
    logic [DIST_W-1:0]         rem_sh;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // Subtracts the closest-point offset, truncated toward zero, from a point offset.
    function automatic logic signed [DIFF_W-1:0] off_sub(
        input logic signed [DIFF_W-1:0] w,
        input logic                     d_neg,
        input logic [PROD_W-1:0]        prod
    );
        logic [OFS_W-1:0]        o_mag;
        logic signed [OFS_W-1:0] o_sgn;
        logic signed [EXT_W-1:0] e;
        o_mag = OFS_W'(prod >> FRACTION_BITS);
        o_sgn = d_neg ? -$signed(o_mag) : $signed(o_mag);
        e     = EXT_W'(w) - EXT_W'(o_sgn);
        return DIFF_W'(e);
    endfunction

    always_comb begin
        unique case (r_state)
            S_LX:    begin mul_a = mag(r_dx);       mul_b = mag(r_dx); end
            S_LZ:    begin mul_a = mag(r_dz);       mul_b = mag(r_dz); end
            S_WX:    begin mul_a = mag(r_wx);       mul_b = mag(r_dx); end
            S_WZ:    begin mul_a = mag(r_wz);       mul_b = mag(r_dz); end
            S_OX:    begin mul_a = MAG_W'(r_tq);    mul_b = mag(r_dx); end
            S_OZ:    begin mul_a = MAG_W'(r_tq);    mul_b = mag(r_dz); end
            S_EX:    begin mul_a = mag(r_ex);       mul_b = mag(r_ex); end
            S_EZ:    begin mul_a = mag(r_ez);       mul_b = mag(r_ez); end
            default: begin mul_a = '0;              mul_b = '0;        end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n1 = r_wx[DIFF_W-1] != r_dx[DIFF_W-1];
        n2 = r_wz[DIFF_W-1] != r_dz[DIFF_W-1];
        priority if (n1 == n2) begin
            n_dot = r_p1 + r_prod;
            n_neg = n1;
        end else if (r_p1 >= r_prod) begin
            n_dot = r_p1 - r_prod;
            n_neg = n1;
        end else begin
            n_dot = r_prod - r_p1;
            n_neg = n2;
        end
    end

    assign rem_sh = r_rem << 1;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_dx    <= DIFF_W'($signed(i_seg.bx)) - DIFF_W'($signed(i_seg.ax));
                        r_dz    <= DIFF_W'($signed(i_seg.bz)) - DIFF_W'($signed(i_seg.az));
                        r_wx    <= DIFF_W'($signed(i_seg.px)) - DIFF_W'($signed(i_seg.ax));
                        r_wz    <= DIFF_W'($signed(i_seg.pz)) - DIFF_W'($signed(i_seg.az));
                        r_state <= S_LX;
                    end
                end
                S_LX: r_state <= S_LZ;
                S_LZ: begin
                    r_len   <= DIST_W'(r_prod);
                    r_state <= S_WX;
                end
                S_WX: begin
                    r_len   <= r_len + DIST_W'(r_prod);
                    r_state <= S_WZ;
                end
                S_WZ: begin
                    r_p1    <= r_prod;
                    r_state <= S_DOT;
                end
                S_DOT: begin
                    r_dot   <= n_dot;
                    r_neg   <= n_neg;
                    r_state <= S_TQ;
                end
                S_TQ: begin
                    r_rem <= DIST_W'(r_dot);
                    r_cnt <= '0;
                    priority if (r_len <= LEN_THRESHOLD || r_neg || r_dot == '0) begin
                        r_tq    <= '0;
                        r_state <= S_OX;
                    end else if (DIST_W'(r_dot) >= r_len) begin
                        r_tq    <= TQ_ONE;
                        r_state <= S_OX;
                    end else begin
                        r_tq    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_sh >= r_len) begin
                        r_rem <= rem_sh - r_len;
                        r_tq  <= {r_tq[TQ_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_tq  <= {r_tq[TQ_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_OX;
                    end
                end
                S_OX: r_state <= S_OZ;
                S_OZ: begin
                    r_ex    <= off_sub(r_wx, r_dx[DIFF_W-1], r_prod);
                    r_state <= S_EX;
                end
                S_EX: begin
                    r_ez    <= off_sub(r_wz, r_dz[DIFF_W-1], r_prod);
                    r_state <= S_EZ;
                end
                S_EZ: begin
                    r_acc   <= r_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_dist  <= DIST_W'(r_acc) + DIST_W'(r_prod);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_dist_sq = r_dist;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for polyline_hit_test_xz: clear, append, query and unused items
// under several tolerance settings, each result checked against a local predictor.
// Depends on phx_pkg and the polyline_hit_test_xz RTL.
module testbench;
    import phx_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEF;
    localparam int ONE = 1 << FRAC;
    localparam int VMAX = MAX_VERTICES_DEF;
    localparam longint SHORT_SEG_LIMIT = (64'd1 << (2 * FRAC)) / 64'd100000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 65;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    t_item            i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [TOL_W-1:0] i_cfg_wdata = '0;
    logic             o_done;
    t_result          o_result;

    t_item   pending_items[$];
    t_result expected_results[$];

    logic signed [COORD_W-1:0] track_x [0:VMAX-1];
    logic signed [COORD_W-1:0] track_z [0:VMAX-1];
    int                        track_len = 0;
    logic [TOL_W-1:0]          tol_model = 31'd65536;

    int   mismatches = 0;
    int   items_queued = 0;
    int   accepted_count = 0;
    int   idle_left = 0;
    logic drain_hold = 1'b0;
    logic quiet_phase = 1'b0;

    polyline_hit_test_xz dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic segment_in_reach(
        input logic signed [COORD_W-1:0] px, pz, ax, az, bx, bz,
        input logic [TOL_W-1:0] tol
    );
        logic signed [127:0] pxe, pze, axe, aze, bxe, bze, tole;
        logic signed [127:0] dx, dz, wx, wz, seg_len, dot, tq, ox, oz, ex, ez, dist_sq;
        pxe = px;
        pze = pz;
        axe = ax;
        aze = az;
        bxe = bx;
        bze = bz;
        tole = tol;
        dx = bxe - axe;
        dz = bze - aze;
        wx = pxe - axe;
        wz = pze - aze;
        seg_len = dx * dx + dz * dz;
        tq = 0;
        if (seg_len > SHORT_SEG_LIMIT) begin
            dot = wx * dx + wz * dz;
            if (dot > 0) begin
                if (dot >= seg_len) tq = ONE;
                else tq = (dot <<< FRAC) / seg_len;
            end
        end
        ox = (tq * (dx < 0 ? -dx : dx)) >>> FRAC;
        oz = (tq * (dz < 0 ? -dz : dz)) >>> FRAC;
        ex = wx - (dx < 0 ? -ox : ox);
        ez = wz - (dz < 0 ? -oz : oz);
        dist_sq = ex * ex + ez * ez;
        return dist_sq <= tole * tole;
    endfunction

    function automatic t_result query_outcome(input logic signed [COORD_W-1:0] px, pz);
        t_result r;
        r.hit = 1'b0;
        r.vertex_count = VCOUNT_W'(track_len);
        for (int i = 1; i < track_len; i++) begin
            if (segment_in_reach(px, pz, track_x[i-1], track_z[i-1], track_x[i], track_z[i],
                                 tol_model)) begin
                r.hit = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    task automatic apply_item(input t_item it);
        case (it.command)
            CMD_CLEAR: track_len = 0;
            CMD_APPEND: begin
                if (track_len < VMAX) begin
                    track_x[track_len] = it.coord_x;
                    track_z[track_len] = it.coord_z;
                    track_len++;
                end
            end
            CMD_QUERY: expected_results.push_back(query_outcome(it.coord_x, it.coord_z));
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : drive
        t_item next_item;
        logic  next_start;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_item <= '0;
        end else begin
            next_start = i_start;
            next_item = i_item;
            if (i_start && !o_busy) begin
                apply_item(i_item);
                accepted_count++;
                next_start = 1'b0;
                if (!quiet_phase) begin
                    if ($urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 6);
                    if (accepted_count % 53 == 0) drain_hold = 1'b1;
                end
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (drain_hold && (expected_results.size() != 0 || o_busy)) begin
                    next_start = 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    next_start = 1'b1;
                    drain_hold = 1'b0;
                end
            end
            i_start <= next_start;
            i_item <= next_item;
        end
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: hit %0b count %0d",
                             o_result.hit, o_result.vertex_count);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.hit !== want.hit || o_result.vertex_count !== want.vertex_count) begin
                    if (mismatches < 10)
                        $display("result mismatch: hit %0b/%0b count %0d/%0d (want/got)",
                                 want.hit, o_result.hit, want.vertex_count,
                                 o_result.vertex_count);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_item(input logic [1:0] cmd, input logic [COORD_W-1:0] x, z);
        t_item it;
        it.command = t_cmd'(cmd);
        it.coord_x = x;
        it.coord_z = z;
        pending_items.push_back(it);
        if (cmd != CMD_UNUSED) items_queued++;
    endtask

    function automatic logic [COORD_W-1:0] near_coord();
        return COORD_W'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
    endfunction

    function automatic logic [COORD_W-1:0] jitter(input logic [COORD_W-1:0] c);
        return c + COORD_W'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
    endfunction

    task automatic queue_random_run();
        logic signed [COORD_W-1:0] rx [0:7];
        logic signed [COORD_W-1:0] rz [0:7];
        int     nv;
        int     nq;
        int     k;
        logic   wide;
        longint mx;
        longint mz;
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        wide = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) != 0) queue_item(CMD_CLEAR, $urandom, $urandom);
        for (int i = 0; i < nv; i++) begin
            rx[i] = wide ? $urandom : near_coord();
            rz[i] = wide ? $urandom : near_coord();
            queue_item(CMD_APPEND, rx[i], rz[i]);
        end
        nq = $urandom_range(1, 4);
        for (int q = 0; q < nq; q++) begin
            k = (nv > 0) ? $urandom_range(0, nv - 1) : 0;
            case ((nv > 0) ? $urandom_range(0, 3) : 2)
                0: queue_item(CMD_QUERY, jitter(rx[k]), jitter(rz[k]));
                1: queue_item(CMD_QUERY, rx[k], rz[k]);
                2: queue_item(CMD_QUERY, $urandom, $urandom);
                default: begin
                    if (k == nv - 1) k = (k > 0) ? k - 1 : k;
                    mx = (longint'(rx[k]) + longint'(rx[(k + 1) % nv])) >>> 1;
                    mz = (longint'(rz[k]) + longint'(rz[(k + 1) % nv])) >>> 1;
                    queue_item(CMD_QUERY, jitter(mx[COORD_W-1:0]), jitter(mz[COORD_W-1:0]));
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0) queue_item(CMD_UNUSED, $urandom, $urandom);
    endtask

    task automatic queue_full_track();
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        x = near_coord();
        z = near_coord();
        queue_item(CMD_CLEAR, 0, 0);
        for (int i = 0; i < VMAX + 4; i++) begin
            x = x + COORD_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
            z = z + COORD_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
            queue_item(CMD_APPEND, x, z);
        end
        queue_item(CMD_QUERY, 32'h7fff_0000, 32'h8000_0000);
        queue_item(CMD_QUERY, x, z);
        queue_item(CMD_QUERY, jitter(x), jitter(z));
    endtask

    task automatic wait_for_idle();
        while (pending_items.size() != 0 || i_start || o_busy || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        tol_model = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [TOL_W-1:0] tol_steps [0:4];
        tol_steps[0] = '0;
        tol_steps[1] = 31'h7fff_ffff;
        tol_steps[2] = 31'd1;
        tol_steps[3] = TOL_W'($urandom_range(ONE / 4, 4 * ONE));
        tol_steps[4] = TOL_W'(2 * ONE);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(CMD_QUERY, 0, 0);
        queue_item(CMD_APPEND, 0, 0);
        queue_item(CMD_QUERY, 0, 0);
        queue_item(CMD_APPEND, 4 * ONE, 0);
        queue_item(CMD_QUERY, 2 * ONE, ONE / 2);
        queue_item(CMD_QUERY, 2 * ONE, 2 * ONE);
        queue_item(CMD_QUERY, -ONE / 2, 0);
        queue_item(CMD_QUERY, 6 * ONE, 0);
        queue_item(CMD_QUERY, 5 * ONE, 0);
        queue_item(CMD_APPEND, 4 * ONE + 3, 2);
        queue_item(CMD_QUERY, 4 * ONE, 2 * ONE);
        queue_item(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff);
        queue_item(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        queue_item(CMD_QUERY, 0, 0);
        queue_item(CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_item(CMD_QUERY, 32'h8000_0000, 32'h8000_0000);
        queue_item(CMD_UNUSED, 32'hffff_ffff, 32'h8000_0000);
        queue_item(CMD_QUERY, 3 * ONE, 5 * ONE);
        queue_item(CMD_CLEAR, 0, 0);
        queue_item(CMD_QUERY, 0, 0);
        queue_item(CMD_APPEND, ONE, ONE);
        queue_item(CMD_APPEND, ONE, ONE);
        queue_item(CMD_QUERY, ONE, ONE + ONE / 2);
        queue_item(CMD_QUERY, ONE, 3 * ONE);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                wait_for_idle();
                write_tolerance(tol_steps[phase - 1]);
            end
            quiet_phase = (phase == 5);
            if (phase == 1) queue_full_track();
            items_queued = 0;
            while (items_queued < PHASE_ITEMS) queue_random_run();
        end

        wait_for_idle();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
